[sv/gspf_pkg.sv]
// Package for the grid shape pixel fill block: item and result types, the
// configuration bundle, register indexes, shape modes and the scale reciprocal table.
// Depends on nothing; every other file in sv/ imports it.
package gspf_pkg;

    localparam int PIX_W     = 9;
    localparam int COLOUR_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int MAX_GRID  = 64;
    localparam int MAX_SCALE = 16;

    localparam int RECIP_SHIFT = 14;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = PIX_W + RECIP_W;
    localparam int GRID_W      = 7;
    localparam int SCALE_W     = 5;
    localparam int DIFF_W      = 11;
    localparam int MAG_W       = 8;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int QUAD_W      = 2 * SQ_W;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_RECT    = 2'd1,
        MODE_ELLIPSE = 2'd2,
        MODE_NONE    = 2'd3
    } shape_mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_W     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_H     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SCALE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOUR = 3'd7;

    // Ceiling of 2^RECIP_SHIFT / scale; exact quotients for all 9-bit pixels.
    localparam logic [RECIP_W-1:0] SCALE_RECIP [MAX_SCALE+1] = '{
        15'd16384, 15'd16384, 15'd8192, 15'd5462, 15'd4096, 15'd3277,
        15'd2731, 15'd2341, 15'd2048, 15'd1821, 15'd1639, 15'd1490,
        15'd1366, 15'd1261, 15'd1171, 15'd1093, 15'd1024
    };

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } gspf_in_t;

    typedef struct packed {
        logic                write_pixel;
        logic [COLOUR_W-1:0] pixel_colour;
        logic [PIX_W-1:0]    out_x;
        logic [PIX_W-1:0]    out_y;
    } gspf_out_t;

    typedef struct packed {
        shape_mode_t         mode;
        logic [7:0]          shape_x;
        logic [7:0]          shape_y;
        logic [8:0]          shape_w;
        logic [8:0]          shape_h;
        logic [GRID_W-1:0]   grid;
        logic [RECIP_W-1:0]  recip;
        logic [SQ_W-1:0]     rx2;
        logic [SQ_W-1:0]     ry2;
        logic [QUAD_W-1:0]   rxry;
        logic [COLOUR_W-1:0] colour;
    } gspf_cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic             in_grid;
        logic             rect_hit;
        logic             ell_ok;
        logic [MAG_W-1:0] dx_mag;
        logic [MAG_W-1:0] dy_mag;
    } gspf_cell_t;

endpackage

[sv/gspf_cfg.sv]
// Configuration registers of the grid shape pixel fill block, with the
// saturated scale reciprocal and the radius products kept in registers.
// Depends on gspf_pkg.
module gspf_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gspf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gspf_pkg::CFG_DAT_W-1:0]  cfg_data,
    output gspf_pkg::gspf_cfg_t             cfg
);
    import gspf_pkg::*;

    logic [1:0]          mode_reg;
    logic [7:0]          shape_x_reg;
    logic [7:0]          shape_y_reg;
    logic [8:0]          shape_w_reg;
    logic [8:0]          shape_h_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic [GRID_W-1:0]   grid_size_reg;
    logic [COLOUR_W-1:0] colour_reg;
    logic [RECIP_W-1:0]  recip_reg;
    logic [SQ_W-1:0]     rx2_reg;
    logic [SQ_W-1:0]     ry2_reg;
    logic [QUAD_W-1:0]   rxry_reg;

    logic [SCALE_W-1:0]  scale_eff;
    logic [GRID_W-1:0]   grid_eff;
    logic [RECIP_W-1:0]  recip_next;
    logic [SQ_W-1:0]     rx2_next;
    logic [SQ_W-1:0]     ry2_next;
    logic [QUAD_W-1:0]   rxry_next;

    always_comb
    begin
        if (scale_reg == '0)
        begin
            scale_eff = SCALE_W'(1);
        end
        else if (scale_reg > SCALE_W'(MAX_SCALE))
        begin
            scale_eff = SCALE_W'(MAX_SCALE);
        end
        else
        begin
            scale_eff = scale_reg;
        end
        grid_eff   = (grid_size_reg > GRID_W'(MAX_GRID)) ? GRID_W'(MAX_GRID) : grid_size_reg;
        recip_next = SCALE_RECIP[scale_eff];
        rx2_next   = shape_w_reg[MAG_W-1:0] * shape_w_reg[MAG_W-1:0];
        ry2_next   = shape_h_reg[MAG_W-1:0] * shape_h_reg[MAG_W-1:0];
        rxry_next  = rx2_reg * ry2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_CLEAR;
            shape_x_reg   <= '0;
            shape_y_reg   <= '0;
            shape_w_reg   <= '0;
            shape_h_reg   <= '0;
            scale_reg     <= SCALE_W'(1);
            grid_size_reg <= GRID_W'(16);
            colour_reg    <= '0;
            recip_reg     <= SCALE_RECIP[1];
            rx2_reg       <= '0;
            ry2_reg       <= '0;
            rxry_reg      <= '0;
        end
        else
        begin
            recip_reg <= recip_next;
            rx2_reg   <= rx2_next;
            ry2_reg   <= ry2_next;
            rxry_reg  <= rxry_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SHAPE_MODE:  mode_reg      <= cfg_data[1:0];
                    REG_SHAPE_X:     shape_x_reg   <= cfg_data[7:0];
                    REG_SHAPE_Y:     shape_y_reg   <= cfg_data[7:0];
                    REG_SHAPE_W:     shape_w_reg   <= cfg_data[8:0];
                    REG_SHAPE_H:     shape_h_reg   <= cfg_data[8:0];
                    REG_CELL_SCALE:  scale_reg     <= cfg_data[SCALE_W-1:0];
                    REG_GRID_SIZE:   grid_size_reg <= cfg_data[GRID_W-1:0];
                    REG_FILL_COLOUR: colour_reg    <= cfg_data[COLOUR_W-1:0];
                    default:         mode_reg      <= mode_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        cfg.mode    = shape_mode_t'(mode_reg);
        cfg.shape_x = shape_x_reg;
        cfg.shape_y = shape_y_reg;
        cfg.shape_w = shape_w_reg;
        cfg.shape_h = shape_h_reg;
        cfg.grid    = grid_eff;
        cfg.recip   = recip_reg;
        cfg.rx2     = rx2_reg;
        cfg.ry2     = ry2_reg;
        cfg.rxry    = rxry_reg;
        cfg.colour  = colour_reg;
    end

endmodule

[sv/gspf_map.sv]
// First two pipeline stages: pixel to grid cell by reciprocal multiply, then
// cell offsets and the grid, rectangle and ellipse bound tests.
// Depends on gspf_pkg.
module gspf_map (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  gspf_pkg::gspf_in_t   in_item,
    input  gspf_pkg::gspf_cfg_t  cfg,
    output logic                 cell_valid,
    output gspf_pkg::gspf_cell_t cell_item
);
    import gspf_pkg::*;

    logic              a_valid_reg;
    logic [PIX_W-1:0]  a_px_reg;
    logic [PIX_W-1:0]  a_py_reg;
    logic [PROD_W-1:0] a_prodx_reg;
    logic [PROD_W-1:0] a_prody_reg;

    logic       b_valid_reg;
    gspf_cell_t b_cell_reg;
    gspf_cell_t b_cell_next;

    logic [PIX_W-1:0]         cx;
    logic [PIX_W-1:0]         cy;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] sx_ext;
    logic signed [DIFF_W-1:0] sy_ext;
    logic signed [DIFF_W-1:0] sw_ext;
    logic signed [DIFF_W-1:0] sh_ext;
    logic signed [DIFF_W-1:0] neg_sw;
    logic signed [DIFF_W-1:0] neg_sh;
    logic signed [DIFF_W-1:0] zero_s;
    logic signed [DIFF_W-1:0] abs_dx;
    logic signed [DIFF_W-1:0] abs_dy;
    logic                     rx_pos;
    logic                     ry_pos;

    always_comb
    begin
        cx     = a_prodx_reg[RECIP_SHIFT +: PIX_W];
        cy     = a_prody_reg[RECIP_SHIFT +: PIX_W];
        sx_ext = {{(DIFF_W-8){cfg.shape_x[7]}}, cfg.shape_x};
        sy_ext = {{(DIFF_W-8){cfg.shape_y[7]}}, cfg.shape_y};
        sw_ext = {{(DIFF_W-9){cfg.shape_w[8]}}, cfg.shape_w};
        sh_ext = {{(DIFF_W-9){cfg.shape_h[8]}}, cfg.shape_h};
        neg_sw = -sw_ext;
        neg_sh = -sh_ext;
        zero_s = '0;
        dx     = $signed({{(DIFF_W-PIX_W){1'b0}}, cx}) - sx_ext;
        dy     = $signed({{(DIFF_W-PIX_W){1'b0}}, cy}) - sy_ext;
        abs_dx = (dx < zero_s) ? -dx : dx;
        abs_dy = (dy < zero_s) ? -dy : dy;
        rx_pos = sw_ext > zero_s;
        ry_pos = sh_ext > zero_s;

        b_cell_next.px       = a_px_reg;
        b_cell_next.py       = a_py_reg;
        b_cell_next.in_grid  = (cx < {{(PIX_W-GRID_W){1'b0}}, cfg.grid})
                            && (cy < {{(PIX_W-GRID_W){1'b0}}, cfg.grid});
        b_cell_next.rect_hit = (dx >= zero_s) && (dx < sw_ext)
                            && (dy >= zero_s) && (dy < sh_ext);
        b_cell_next.ell_ok   = rx_pos && ry_pos
                            && (dx >= neg_sw) && (dx <= sw_ext)
                            && (dy >= neg_sh) && (dy <= sh_ext);
        b_cell_next.dx_mag   = abs_dx[MAG_W-1:0];
        b_cell_next.dy_mag   = abs_dy[MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_px_reg    <= in_item.pixel_x;
        a_py_reg    <= in_item.pixel_y;
        a_prodx_reg <= in_item.pixel_x * cfg.recip;
        a_prody_reg <= in_item.pixel_y * cfg.recip;
        b_cell_reg  <= b_cell_next;
    end

    assign cell_valid = b_valid_reg;
    assign cell_item  = b_cell_reg;

endmodule

[sv/gspf_test.sv]
// Last three pipeline stages: offset squares, radius-weighted products and
// the ellipse compare, then the per-mode write decision into the result register.
// Depends on gspf_pkg.
module gspf_test (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cell_valid,
    input  gspf_pkg::gspf_cell_t cell_item,
    input  gspf_pkg::gspf_cfg_t  cfg,
    output logic                 result_valid,
    output gspf_pkg::gspf_out_t  result
);
    import gspf_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic             in_grid;
        logic             rect_hit;
        logic             ell_ok;
    } flags_t;

    logic             c_valid_reg;
    flags_t           c_flags_reg;
    logic [SQ_W-1:0]  c_dx2_reg;
    logic [SQ_W-1:0]  c_dy2_reg;

    logic              d_valid_reg;
    flags_t            d_flags_reg;
    logic [QUAD_W-1:0] d_a_reg;
    logic [QUAD_W-1:0] d_b_reg;

    logic        result_valid_reg;
    gspf_out_t   result_reg;
    gspf_out_t   result_next;

    logic [QUAD_W:0] sum;
    logic            ell_in;

    always_comb
    begin
        sum    = {1'b0, d_a_reg} + {1'b0, d_b_reg};
        ell_in = sum <= {1'b0, cfg.rxry};

        result_next.pixel_colour = cfg.colour;
        result_next.out_x        = d_flags_reg.px;
        result_next.out_y        = d_flags_reg.py;
        unique case (cfg.mode)
            MODE_CLEAR:   result_next.write_pixel = 1'b1;
            MODE_RECT:    result_next.write_pixel = d_flags_reg.in_grid
                                                  && d_flags_reg.rect_hit;
            MODE_ELLIPSE: result_next.write_pixel = d_flags_reg.in_grid
                                                  && d_flags_reg.ell_ok && ell_in;
            MODE_NONE:    result_next.write_pixel = 1'b0;
            default:      result_next.write_pixel = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg      <= 1'b0;
            d_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg      <= cell_valid;
            d_valid_reg      <= c_valid_reg;
            result_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_flags_reg.px       <= cell_item.px;
        c_flags_reg.py       <= cell_item.py;
        c_flags_reg.in_grid  <= cell_item.in_grid;
        c_flags_reg.rect_hit <= cell_item.rect_hit;
        c_flags_reg.ell_ok   <= cell_item.ell_ok;
        c_dx2_reg            <= cell_item.dx_mag * cell_item.dx_mag;
        c_dy2_reg            <= cell_item.dy_mag * cell_item.dy_mag;
        d_flags_reg          <= c_flags_reg;
        d_a_reg              <= c_dx2_reg * cfg.ry2;
        d_b_reg              <= c_dy2_reg * cfg.rx2;
        result_reg           <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[sv/grid_shape_pixel_fill.sv]
// Top level of the grid shape pixel fill block: configuration registers and
// the five-stage coverage pipeline. Depends on gspf_pkg, gspf_cfg, gspf_map, gspf_test.
//
// The block takes one pixel in every clock cycle and never raises busy; each
// item gives exactly one result, strobed by result_valid, in the order taken.
// The item passes through five register stages, the first of which loads at
// the accepting edge: the reciprocal multiply that maps a pixel to its cell,
// the offset and bound tests, the offset squares, the radius-weighted products
// and the final compare. The receiver cannot hold results off, so results must
// be taken in the cycle they appear. A register write takes effect once the
// derived scale reciprocal and radius products, held in registers, settle.
module grid_shape_pixel_fill (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  gspf_pkg::gspf_in_t              in_item,
    output logic                            result_valid,
    output gspf_pkg::gspf_out_t             result,
    input  logic                            cfg_we,
    input  logic [gspf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gspf_pkg::CFG_DAT_W-1:0]  cfg_data
);
    import gspf_pkg::*;

    gspf_cfg_t  cfg;
    logic       cell_valid;
    gspf_cell_t cell_item;

    assign busy = 1'b0;

    gspf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gspf_map u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .in_item    (in_item),
        .cfg        (cfg),
        .cell_valid (cell_valid),
        .cell_item  (cell_item)
    );

    gspf_test u_test (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_valid   (cell_valid),
        .cell_item    (cell_item),
        .cfg          (cfg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
